// ===== rtl/alr_pkg.sv =====
// types, codes and sample arithmetic shared by the audio looper
package alr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 20;
    localparam int LEN_W    = 21;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [LEN_W-1:0] CAPACITY_RESET = 21'h100000;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_CYCLE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RECORD  = 2'd1,
        MODE_PLAY    = 2'd2,
        MODE_OVERDUB = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_PASS,
        ACT_ZERO,
        ACT_STORE,
        ACT_PLAY,
        ACT_DUB
    } act_t;

    typedef struct packed {
        logic [1:0]                 operation;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [1:0]                 mode;
        logic [POS_W-1:0]           position;
        logic [LEN_W-1:0]           loop_length;
    } out_t;

    function automatic logic signed [SAMPLE_W-1:0] add_sat16(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W:0]          sum;
        logic signed [SAMPLE_W-1:0] res;
        sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        case (sum[SAMPLE_W:SAMPLE_W-1])
            2'b01:   res = SAMPLE_MAX;
            2'b10:   res = SAMPLE_MIN;
            default: res = sum[SAMPLE_W-1:0];
        endcase
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] mono_mean(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        logic [SAMPLE_W:0] sum;
        sum = {l[SAMPLE_W-1], l} + {r[SAMPLE_W-1], r};
        return sum[SAMPLE_W:1];
    endfunction

endpackage

// ===== rtl/audio_loop_recorder_overdub.sv =====
// mono audio looper top level: record, play and overdub over one loop memory
// The looper takes one item (stereo frame, cycle press or clear press) per clock while the
// output side does not stall and returns one result per item via stage one and the output
// register. The rate is set by the loop memory: one read at transfer and one write-back as it
// leaves stage one, with the written sample forwarded to a read of the same entry issued in
// that cycle, so a loop of length one still runs at full rate. An output register parts the
// two sides, so a new item is taken while a finished result waits. The loop memory holds
// MEMORY_DEPTH samples, at most 2^21 (2^21 - 1 usable through the capacity register), and
// needs no clearing pass: an entry is only read after it has been recorded. The capacity
// register may be written only while no item is in flight; zero disables the looper.
module audio_loop_recorder_overdub #(
    parameter int MEMORY_DEPTH = 1048576
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       frame_valid,
    output logic                       frame_stall,
    input  alr_pkg::in_t               frame,
    output logic                       result_valid,
    input  logic                       result_stall,
    output alr_pkg::out_t              result,
    input  logic                       capacity_we,
    input  logic [alr_pkg::LEN_W-1:0]  capacity_data
);

    localparam int USED_DEPTH = (MEMORY_DEPTH > (1 << alr_pkg::LEN_W)) ?
                                (1 << alr_pkg::LEN_W) : MEMORY_DEPTH;
    localparam int AW         = $clog2(USED_DEPTH);
    localparam int XW         = alr_pkg::LEN_W + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(USED_DEPTH);

    // architectural state
    alr_pkg::mode_t              mode_reg, mode_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [alr_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [alr_pkg::LEN_W-1:0]   capacity_reg;

    // stage one: memory read in flight
    logic                        s1_valid_reg, s1_valid_next;
    alr_pkg::act_t               s1_act_reg, act_next;
    logic signed [15:0]          s1_left_reg, s1_right_reg, s1_mono_reg;
    logic [AW-1:0]               s1_addr_reg;
    alr_pkg::mode_t              s1_mode_reg;
    logic [AW-1:0]               s1_pos_reg;
    logic [alr_pkg::LEN_W-1:0]   s1_len_reg;
    logic                        fwd_hit_reg, fwd_hit_next;
    logic signed [15:0]          fwd_data_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    alr_pkg::out_t               result_reg, result_next;

    logic                        accept, s1_adv;
    logic [XW-1:0]               cap_x, cap_eff, pos_x, pos_inc, len_x, loop_pos;
    logic                        active, rec_go, rec_full, loop_go;
    logic signed [15:0]          mono_in;
    logic signed [15:0]          ram_rdata, mem_q, dub_s, mix_s;
    logic signed [15:0]          s1_wdata;
    logic                        s1_wr, ram_we;
    logic [alr_pkg::LEN_W-1:0]   s1_pos_x;

    // handshake
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign frame_stall   = s1_valid_reg && !s1_adv;
    assign accept        = frame_valid && !frame_stall;
    assign result_valid  = out_valid_reg;
    assign result        = result_reg;

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (result_stall ? out_valid_reg : 1'b0);

    // stage zero decode
    assign cap_x    = {1'b0, capacity_reg};
    assign cap_eff  = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
    assign active   = (cap_eff != '0);
    assign pos_x    = XW'(pos_reg);
    assign pos_inc  = pos_x + XW'(1);
    assign len_x    = {1'b0, len_reg};
    assign rec_go   = (mode_reg == alr_pkg::MODE_RECORD) && (pos_x < cap_eff);
    assign rec_full = (pos_inc >= cap_eff);
    assign loop_go  = (len_reg != '0);
    assign loop_pos = (pos_inc >= len_x) ? '0 : pos_inc;
    assign mono_in  = alr_pkg::mono_mean(frame.left_in, frame.right_in);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (frame.operation)
            alr_pkg::OP_FRAME:
            begin
                if (active && rec_go && rec_full)
                begin
                    mode_next = alr_pkg::MODE_PLAY;
                end
            end
            alr_pkg::OP_CYCLE:
            begin
                if (active)
                begin
                    unique case (mode_reg)
                        alr_pkg::MODE_IDLE:    mode_next = alr_pkg::MODE_RECORD;
                        alr_pkg::MODE_RECORD:  mode_next = alr_pkg::MODE_PLAY;
                        alr_pkg::MODE_PLAY:    mode_next = alr_pkg::MODE_OVERDUB;
                        alr_pkg::MODE_OVERDUB: mode_next = alr_pkg::MODE_PLAY;
                        default:               mode_next = mode_reg;
                    endcase
                end
            end
            alr_pkg::OP_CLEAR:
            begin
                mode_next = alr_pkg::MODE_IDLE;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // position, length and memory action
    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        act_next = alr_pkg::ACT_ZERO;
        unique case (frame.operation)
            alr_pkg::OP_FRAME:
            begin
                act_next = alr_pkg::ACT_PASS;
                if (active)
                begin
                    unique case (mode_reg)
                        alr_pkg::MODE_RECORD:
                        begin
                            if (rec_go)
                            begin
                                act_next = alr_pkg::ACT_STORE;
                                if (rec_full)
                                begin
                                    len_next = pos_inc[alr_pkg::LEN_W-1:0];
                                    pos_next = '0;
                                end
                                else
                                begin
                                    pos_next = pos_inc[AW-1:0];
                                end
                            end
                        end
                        alr_pkg::MODE_PLAY:
                        begin
                            if (loop_go)
                            begin
                                act_next = alr_pkg::ACT_PLAY;
                                pos_next = loop_pos[AW-1:0];
                            end
                        end
                        alr_pkg::MODE_OVERDUB:
                        begin
                            if (loop_go)
                            begin
                                act_next = alr_pkg::ACT_DUB;
                                pos_next = loop_pos[AW-1:0];
                            end
                        end
                        default:
                        begin
                            act_next = alr_pkg::ACT_PASS;
                        end
                    endcase
                end
            end
            alr_pkg::OP_CYCLE:
            begin
                if (active)
                begin
                    unique case (mode_reg)
                        alr_pkg::MODE_IDLE:
                        begin
                            pos_next = '0;
                            len_next = '0;
                        end
                        alr_pkg::MODE_RECORD:
                        begin
                            len_next = pos_x[alr_pkg::LEN_W-1:0];
                            pos_next = '0;
                        end
                        default:
                        begin
                            pos_next = pos_reg;
                        end
                    endcase
                end
            end
            alr_pkg::OP_CLEAR:
            begin
                pos_next = '0;
                len_next = '0;
            end
            default:
            begin
                act_next = alr_pkg::ACT_ZERO;
            end
        endcase
    end

    // forwarding from the write-back stage into a read issued in the same cycle
    assign fwd_hit_next = s1_adv && s1_wr && (s1_addr_reg == pos_reg);

    // stage one datapath
    assign mem_q    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign dub_s    = alr_pkg::add_sat16(mem_q, s1_mono_reg);
    assign mix_s    = (s1_act_reg == alr_pkg::ACT_DUB) ? dub_s : mem_q;
    assign s1_wr    = (s1_act_reg == alr_pkg::ACT_STORE) || (s1_act_reg == alr_pkg::ACT_DUB);
    assign s1_wdata = (s1_act_reg == alr_pkg::ACT_DUB) ? dub_s : s1_mono_reg;
    assign ram_we   = s1_adv && s1_wr;
    assign s1_pos_x = alr_pkg::LEN_W'(s1_pos_reg);

    always_comb
    begin
        result_next.mode        = s1_mode_reg;
        result_next.position    = s1_pos_x[alr_pkg::POS_W-1:0];
        result_next.loop_length = s1_len_reg;
        case (s1_act_reg) inside
            alr_pkg::ACT_PLAY, alr_pkg::ACT_DUB:
            begin
                result_next.left_out  = alr_pkg::add_sat16(s1_left_reg, mix_s);
                result_next.right_out = alr_pkg::add_sat16(s1_right_reg, mix_s);
            end
            alr_pkg::ACT_ZERO:
            begin
                result_next.left_out  = '0;
                result_next.right_out = '0;
            end
            default:
            begin
                result_next.left_out  = s1_left_reg;
                result_next.right_out = s1_right_reg;
            end
        endcase
    end

    alr_ram #(
        .WIDTH (16),
        .DEPTH (USED_DEPTH)
    ) u_loop_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (s1_wdata),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= alr_pkg::MODE_IDLE;
            pos_reg       <= '0;
            len_reg       <= '0;
            capacity_reg  <= alr_pkg::CAPACITY_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (capacity_we)
            begin
                capacity_reg <= capacity_data;
            end
            if (accept)
            begin
                mode_reg    <= mode_next;
                pos_reg     <= pos_next;
                len_reg     <= len_next;
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg   <= act_next;
            s1_left_reg  <= frame.left_in;
            s1_right_reg <= frame.right_in;
            s1_mono_reg  <= mono_in;
            s1_addr_reg  <= pos_reg;
            s1_mode_reg  <= mode_next;
            s1_pos_reg   <= pos_next;
            s1_len_reg   <= len_next;
            fwd_data_reg <= s1_wdata;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stalled item left stage one");

    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("transfer did not reach stage one");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == alr_pkg::MODE_IDLE |-> pos_reg == '0 && len_reg == '0)
        else $error("idle with position or length set");

    a_pos_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == alr_pkg::MODE_PLAY || mode_reg == alr_pkg::MODE_OVERDUB)
        && len_reg != '0 |-> {1'b0, len_reg} > pos_x)
        else $error("position outside loop");
`endif

endmodule

// ===== rtl/alr_ram.sv =====
// generic single write port ram with registered read
module alr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
